// ----- rtl/display_channel_lru_allocator_assert.svh -----
// assertion macros shared by the channel allocator rtl
`ifndef DISPLAY_CHANNEL_LRU_ALLOCATOR_ASSERT_SVH
`define DISPLAY_CHANNEL_LRU_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DCLA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DCLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dcla_pkg.sv -----
// shared constants, types and helpers for the channel allocator
package dcla_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int NUM_CLIENTS  = 64;
    localparam int NUM_SYNCS    = 15;

    localparam int ACTION_W = 3;
    localparam int CLIENT_W = 6;
    localparam int SYNC_W   = 4;
    localparam int REQ_W    = 8;
    localparam int TIME_W   = 32;
    localparam int CH_OUT_W = 3;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;

    localparam int CH_W      = $clog2(NUM_CHANNELS);
    localparam int CLIENT_AW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int SYNC_AW   = (NUM_SYNCS > 1) ? $clog2(NUM_SYNCS) : 1;
    localparam int OWNER_W   = $clog2(NUM_SYNCS + 1);

    localparam int ENTRY_W    = TIME_W + OWNER_W;
    localparam int CHAN_ROW_W = NUM_CHANNELS * ENTRY_W;
    localparam int SYNC_ROW_W = NUM_CLIENTS * CH_W;

    // reciprocal for the channel modulo of an 8-bit request
    localparam int MOD_SHIFT = 16;
    localparam int RECIP     = (1 << MOD_SHIFT) / NUM_CHANNELS + 1;
    localparam int PROD_W    = REQ_W + MOD_SHIFT + 1;
    localparam int QN_W      = REQ_W + 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CONNECT = 3'd0,
        ACT_CREATE  = 3'd1,
        ACT_AUTO    = 3'd2,
        ACT_MANUAL  = 3'd3,
        ACT_SHOW    = 3'd4,
        ACT_CLEAR   = 3'd5
    } action_t;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] best;
    } lru_status_t;

    function automatic logic [CH_W-1:0] chan_mod(input logic [REQ_W-1:0] v);
        logic [PROD_W-1:0] prod;
        logic [REQ_W-1:0]  q;
        logic [QN_W-1:0]   qn;
        logic [REQ_W-1:0]  r;
        prod = PROD_W'(v) * PROD_W'(RECIP);
        q    = prod[MOD_SHIFT +: REQ_W];
        qn   = QN_W'(q) * QN_W'(NUM_CHANNELS);
        r    = v - qn[REQ_W-1:0];
        return r[CH_W-1:0];
    endfunction

endpackage

// ----- rtl/display_channel_lru_allocator.sv -----
// top level: request sequencer over the channel and synchronizer tables
//
// One request beat enters on the s_axis channel and exactly one result beat
// leaves on the m_axis channel, in order. Each request reads one client row
// of the channel table (six timestamps and owners) and one synchronizer row
// of the last-channel table, decides, and writes back the rows it changes.
// Connect, create and ignored requests go through load, decide and done;
// a write state follows decide when the channel is known (manual, sync
// owned), and a scan before the write when the least recently used channel
// is searched (auto, sync show miss), one timestamp compared per cycle.
// A new request is taken the cycle after the previous result is registered.
// Reset clears per-row valid bits, so every table reads as zero at once;
// connect and create just drop the valid bit of their row, with no sweep.
// When the receiver stalls, the result register holds its beat and the block
// still takes and works on the next request; it then waits with the finished
// result until the register frees.
`include "display_channel_lru_allocator_assert.svh"

module display_channel_lru_allocator
    import dcla_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // action[2:0], client[8:3], sync_id[12:9], requested_channel[20:13], now[52:21]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // channel[2:0], found[3]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int OFS_CLIENT = ACTION_W;
    localparam int OFS_SYNC   = OFS_CLIENT + CLIENT_W;
    localparam int OFS_REQ    = OFS_SYNC + SYNC_W;
    localparam int OFS_NOW    = OFS_REQ + REQ_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - CH_OUT_W - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DECIDE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUM_CLIENTS-1:0]  cvalid_reg, cvalid_next;
    logic [NUM_SYNCS-1:0]    svalid_reg, svalid_next;
    logic                    out_valid_reg, out_valid_next;

    logic [ACTION_W-1:0]     act_reg, act_next;
    logic [CLIENT_W-1:0]     client_reg, client_next;
    logic [SYNC_W-1:0]       sync_reg, sync_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [TIME_W-1:0]       time_row_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]       time_row_next [NUM_CHANNELS];
    logic [OWNER_W-1:0]      owner_row_reg [NUM_CHANNELS];
    logic [OWNER_W-1:0]      owner_row_next [NUM_CHANNELS];
    logic [SYNC_ROW_W-1:0]   sync_row;
    logic [CH_W-1:0]         sel_reg, sel_next;
    logic                    found_reg, found_next;
    logic                    claim_reg, claim_next;
    logic                    clr_owner_reg, clr_owner_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic                    accept;
    logic [CLIENT_W-1:0]     in_client;
    logic [SYNC_W-1:0]       in_sync;
    logic                    in_client_ok;
    logic                    in_sync_ok;
    logic [CLIENT_AW-1:0]    client_idx;
    logic [SYNC_AW-1:0]      sync_idx;
    logic                    client_ok;
    logic                    sync_ok;
    logic [CH_W-1:0]         last_ch;
    logic                    owned;
    logic                    item_ok;

    logic                    chan_re, chan_we, sync_re, sync_we;
    logic [CLIENT_AW-1:0]    chan_raddr;
    logic [SYNC_AW-1:0]      sync_raddr;
    logic [CHAN_ROW_W-1:0]   chan_rdata, chan_wdata;
    logic [SYNC_ROW_W-1:0]   sync_rdata, sync_wdata;

    logic                    lru_start;
    lru_status_t             lru_stat;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_client     = s_axis_tdata[OFS_CLIENT +: CLIENT_W];
    assign in_sync       = s_axis_tdata[OFS_SYNC +: SYNC_W];
    assign in_client_ok  = (32'(in_client) < NUM_CLIENTS);
    assign in_sync_ok    = (in_sync != '0) && (32'(in_sync) <= NUM_SYNCS);
    assign chan_re       = accept && in_client_ok;
    assign sync_re       = accept && in_sync_ok;
    assign chan_raddr    = CLIENT_AW'(in_client);
    assign sync_raddr    = SYNC_AW'(in_sync - SYNC_W'(1));

    assign client_idx = CLIENT_AW'(client_reg);
    assign sync_idx   = SYNC_AW'(sync_reg - SYNC_W'(1));
    assign client_ok  = (32'(client_reg) < NUM_CLIENTS);
    assign sync_ok    = (sync_reg != '0) && (32'(sync_reg) <= NUM_SYNCS);
    // the ram output holds until the next accept; rows without a valid bit read as zero
    assign sync_row   = (sync_ok && svalid_reg[sync_idx]) ? sync_rdata : '0;
    assign last_ch    = sync_row[client_idx * CH_W +: CH_W];
    assign owned      = sync_ok && (32'(last_ch) < NUM_CHANNELS)
                        && (owner_row_reg[last_ch] == OWNER_W'(sync_reg));

    always_comb
    begin
        item_ok = client_ok;
        case (action_t'(act_reg))
            ACT_CONNECT, ACT_AUTO, ACT_MANUAL: item_ok = client_ok;
            ACT_CREATE, ACT_SHOW, ACT_CLEAR:   item_ok = client_ok && sync_ok;
            default:                           item_ok = 1'b0;
        endcase
    end

    // write-back rows: stamp and owner update on the selected channel, selected channel in the client's sync entry
    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            chan_wdata[i*ENTRY_W +: TIME_W] =
                (CH_W'(i) == sel_reg) ? now_reg : time_row_reg[i];
            if (CH_W'(i) == sel_reg && clr_owner_reg)
            begin
                chan_wdata[i*ENTRY_W+TIME_W +: OWNER_W] = '0;
            end
            else if (CH_W'(i) == sel_reg && claim_reg)
            begin
                chan_wdata[i*ENTRY_W+TIME_W +: OWNER_W] = OWNER_W'(sync_reg);
            end
            else
            begin
                chan_wdata[i*ENTRY_W+TIME_W +: OWNER_W] = owner_row_reg[i];
            end
        end
        for (int j = 0; j < NUM_CLIENTS; j++)
        begin
            sync_wdata[j*CH_W +: CH_W] =
                (CLIENT_AW'(j) == client_idx) ? sel_reg : sync_row[j*CH_W +: CH_W];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cvalid_next    = cvalid_reg;
        svalid_next    = svalid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        act_next       = act_reg;
        client_next    = client_reg;
        sync_next      = sync_reg;
        req_next       = req_reg;
        now_next       = now_reg;
        time_row_next  = time_row_reg;
        owner_row_next = owner_row_reg;
        sel_next       = sel_reg;
        found_next     = found_reg;
        claim_next     = claim_reg;
        clr_owner_next = clr_owner_reg;
        out_data_next  = out_data_reg;
        lru_start      = 1'b0;
        chan_we        = 1'b0;
        sync_we        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next    = s_axis_tdata[ACTION_W-1:0];
                    client_next = in_client;
                    sync_next   = in_sync;
                    req_next    = s_axis_tdata[OFS_REQ +: REQ_W];
                    now_next    = s_axis_tdata[OFS_NOW +: TIME_W];
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // rows without a valid bit read as zero
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    time_row_next[i]  = (client_ok && cvalid_reg[client_idx])
                                        ? chan_rdata[i*ENTRY_W +: TIME_W] : '0;
                    owner_row_next[i] = (client_ok && cvalid_reg[client_idx])
                                        ? chan_rdata[i*ENTRY_W+TIME_W +: OWNER_W] : '0;
                end
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                sel_next       = '0;
                found_next     = 1'b0;
                claim_next     = 1'b0;
                clr_owner_next = 1'b0;
                state_next     = ST_DONE;
                if (item_ok)
                begin
                    case (action_t'(act_reg))
                        ACT_CONNECT:
                        begin
                            cvalid_next[client_idx] = 1'b0;
                        end
                        ACT_CREATE:
                        begin
                            svalid_next[sync_idx] = 1'b0;
                        end
                        ACT_AUTO:
                        begin
                            clr_owner_next = 1'b1;
                            lru_start      = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        ACT_MANUAL:
                        begin
                            sel_next       = chan_mod(req_reg);
                            found_next     = 1'b1;
                            clr_owner_next = 1'b1;
                            state_next     = ST_WRITE;
                        end
                        ACT_SHOW:
                        begin
                            if (owned)
                            begin
                                sel_next   = last_ch;
                                found_next = 1'b1;
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                claim_next = 1'b1;
                                lru_start  = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            if (owned)
                            begin
                                sel_next   = last_ch;
                                found_next = 1'b1;
                                state_next = ST_WRITE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (lru_stat.done)
                begin
                    sel_next   = lru_stat.best;
                    found_next = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                chan_we                 = 1'b1;
                cvalid_next[client_idx] = 1'b1;
                if (claim_reg)
                begin
                    sync_we               = 1'b1;
                    svalid_next[sync_idx] = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {OUT_PAD_W'(0), found_reg, CH_OUT_W'(sel_reg)};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cvalid_reg    <= '0;
            svalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cvalid_reg    <= cvalid_next;
            svalid_reg    <= svalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        client_reg    <= client_next;
        sync_reg      <= sync_next;
        req_reg       <= req_next;
        now_reg       <= now_next;
        time_row_reg  <= time_row_next;
        owner_row_reg <= owner_row_next;
        sel_reg       <= sel_next;
        found_reg     <= found_next;
        claim_reg     <= claim_next;
        clr_owner_reg <= clr_owner_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    dcla_ram #(
        .WIDTH (CHAN_ROW_W),
        .DEPTH (NUM_CLIENTS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (chan_we),
        .waddr (client_idx),
        .wdata (chan_wdata),
        .re    (chan_re),
        .raddr (chan_raddr),
        .rdata (chan_rdata)
    );

    dcla_ram #(
        .WIDTH (SYNC_ROW_W),
        .DEPTH (NUM_SYNCS)
    ) u_sync_ram (
        .clk   (clk),
        .we    (sync_we),
        .waddr (sync_idx),
        .wdata (sync_wdata),
        .re    (sync_re),
        .raddr (sync_raddr),
        .rdata (sync_rdata)
    );

    dcla_lru u_lru (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lru_start),
        .times  (time_row_reg),
        .status (lru_stat)
    );

    `DCLA_ASSERT_NEXT(a_accept_loads, accept, state_reg == ST_LOAD, "accept did not start a row read")
    `DCLA_ASSERT_NOW(a_sync_write_claims, sync_we, chan_we && (act_reg == ACT_SHOW), "sync row written outside a sync claim")
    `DCLA_ASSERT_NOW(a_lru_in_range, lru_stat.done, 32'(lru_stat.best) < NUM_CHANNELS, "lru pick out of range")
    `DCLA_ASSERT_NOW(a_lru_done_in_scan, lru_stat.done, state_reg == ST_SCAN, "lru finished outside the scan state")

endmodule

// ----- rtl/dcla_ram.sv -----
// generic single-port-write ram with registered read
module dcla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dcla_lru.sv -----
// iterative least-recently-used search, one timestamp compare per cycle
module dcla_lru
    import dcla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] times [NUM_CHANNELS],
    output lru_status_t       status
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CH_W-1:0]   idx_reg,   idx_next;
    logic [CH_W-1:0]   best_reg,  best_next;
    logic [TIME_W-1:0] btime_reg, btime_next;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        idx_next   = idx_reg;
        best_next  = best_reg;
        btime_next = btime_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            idx_next   = CH_W'(1);
            best_next  = '0;
            btime_next = times[0];
        end
        else if (busy_reg)
        begin
            // strict compare keeps the lowest index on ties
            if (times[idx_reg] < btime_reg)
            begin
                best_next  = idx_reg;
                btime_next = times[idx_reg];
            end
            if (idx_reg == CH_W'(NUM_CHANNELS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + CH_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        btime_reg <= btime_next;
    end

    assign status.done = done_reg;
    assign status.best = best_reg;

endmodule
